// ----- rtl/core/chp_pkg.sv -----
// shared types, constants and the arctangent table of the compass heading core
package chp_pkg;

	// field widths
	localparam int AXIS_W  = 16;
	localparam int SCALE_W = 16;
	localparam int PROD_W  = AXIS_W + SCALE_W + 1;
	localparam int HEAD_W  = 15;

	// cordic datapath formats
	localparam int VEC_SHIFT = 30;
	localparam int VEC_W     = 49;
	localparam int ANG_W     = 31;
	localparam int HSUM_W    = 33;
	localparam int FRAC_BITS = 16;
	localparam int STEPS     = 29;

	// 180 degrees in 1/(64*65536) degree units
	localparam logic signed [HSUM_W-1:0] DEG180 = 33'sd754974720;
	localparam logic [HEAD_W-1:0] HEADING_MAX = 15'd23040;

	// configuration port
	localparam int PADDR_W = 3;
	localparam logic REG_SCALE = 1'b0;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd9830;

	// quadrant correction added after the rotations
	typedef enum logic [1:0] {
		BASE_NONE,
		BASE_POS,
		BASE_NEG
	} base_t;

	// payload carried through the rotation stages
	typedef struct packed {
		logic                     err;
		logic                     y_zero;
		base_t                    base;
		logic signed [VEC_W-1:0]  x;
		logic signed [VEC_W-1:0]  y;
		logic signed [ANG_W-1:0]  z;
		logic signed [AXIS_W-1:0] sx;
		logic signed [AXIS_W-1:0] sy;
		logic signed [AXIS_W-1:0] sz;
	} cordic_t;

	// finished result beat
	typedef struct packed {
		logic signed [AXIS_W-1:0] scaled_x;
		logic signed [AXIS_W-1:0] scaled_y;
		logic signed [AXIS_W-1:0] scaled_z;
		logic [HEAD_W-1:0]        heading_deg64;
		logic                     status;
	} result_t;

	// atan(2^-step) in 1/(64*65536) degree units
	function automatic logic signed [ANG_W-1:0] atan_entry(input int step);
		case (step)
			0:       return 31'sd188743680;
			1:       return 31'sd111421900;
			2:       return 31'sd58872272;
			3:       return 31'sd29884485;
			4:       return 31'sd15000234;
			5:       return 31'sd7507429;
			6:       return 31'sd3754631;
			7:       return 31'sd1877430;
			8:       return 31'sd938729;
			9:       return 31'sd469366;
			10:      return 31'sd234683;
			11:      return 31'sd117342;
			12:      return 31'sd58671;
			13:      return 31'sd29335;
			14:      return 31'sd14668;
			15:      return 31'sd7334;
			16:      return 31'sd3667;
			17:      return 31'sd1833;
			18:      return 31'sd917;
			19:      return 31'sd458;
			20:      return 31'sd229;
			21:      return 31'sd115;
			22:      return 31'sd57;
			23:      return 31'sd29;
			24:      return 31'sd14;
			25:      return 31'sd7;
			26:      return 31'sd4;
			27:      return 31'sd2;
			28:      return 31'sd1;
			default: return 31'sd0;
		endcase
	endfunction

endpackage

// ----- rtl/core/chp_in_if.sv -----
// sample channel: raw magnetometer axes and read error flag
interface chp_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [chp_pkg::AXIS_W-1:0]     raw_x;
	logic signed [chp_pkg::AXIS_W-1:0]     raw_y;
	logic signed [chp_pkg::AXIS_W-1:0]     raw_z;
	logic                                  read_error;

	modport source (output valid, raw_x, raw_y, raw_z, read_error, input ready);
	modport sink (input valid, raw_x, raw_y, raw_z, read_error, output ready);
endinterface

// ----- rtl/core/chp_out_if.sv -----
// result channel: scaled axes, heading and status
interface chp_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [chp_pkg::AXIS_W-1:0]     scaled_x;
	logic signed [chp_pkg::AXIS_W-1:0]     scaled_y;
	logic signed [chp_pkg::AXIS_W-1:0]     scaled_z;
	logic [chp_pkg::HEAD_W-1:0]            heading_deg64;
	logic                                  status;

	modport source (output valid, scaled_x, scaled_y, scaled_z, heading_deg64, status,
		input ready);
	modport sink (input valid, scaled_x, scaled_y, scaled_z, heading_deg64, status,
		output ready);
endinterface

// ----- rtl/core/compass_heading_from_magnetometer_core.sv -----
// top level of the compass heading core: register port, pipeline and result beat
// Takes one magnetometer sample beat per cycle and returns one result beat per sample,
// in order. Each axis is scaled by the scale_q16 register (byte address 0) and the
// heading atan2(scaled x, scaled y) + 180 degrees comes out in 1/64 degree steps.
// The pipeline has three front stages (multiply, truncate, vector setup), 29 cordic
// rotation stages of two 49-bit adds and one angle add each, and two stages for
// quadrant correction, rounding and clamping. Throughput is one beat per cycle; when
// the result beat is not taken the whole pipeline holds and the sample side is not
// ready. Write scale_q16 only while no sample is in flight.
module compass_heading_from_magnetometer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [chp_pkg::PADDR_W-1:0]     paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	chp_in_if.sink                          sample,
	chp_out_if.source                       result
);

	localparam int STEPS = chp_pkg::STEPS;

	logic                            adv;
	logic [chp_pkg::SCALE_W-1:0]     scale_q;
	logic                            cfg_wr;
	logic                            chain_v [0:STEPS];
	chp_pkg::cordic_t                chain_d [0:STEPS];
	logic                            fin_valid;
	chp_pkg::result_t                fin_data;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= chp_pkg::SCALE_RESET;
		end else if (cfg_wr && (paddr[2] == chp_pkg::REG_SCALE)) begin
			scale_q <= pwdata[chp_pkg::SCALE_W-1:0];
		end
	end

	assign prdata = (paddr[2] == chp_pkg::REG_SCALE) ?
		{{(32 - chp_pkg::SCALE_W){1'b0}}, scale_q} : '0;

	// the pipeline moves whenever the result register is free or being taken
	assign adv          = !fin_valid || result.ready;
	assign sample.ready = adv;

	chp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (sample.valid),
		.raw_x      (sample.raw_x),
		.raw_y      (sample.raw_y),
		.raw_z      (sample.raw_z),
		.read_error (sample.read_error),
		.scale      (scale_q),
		.out_valid  (chain_v[0]),
		.out_data   (chain_d[0])
	);

	// rotation stages
	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		chp_cordic_stage #(
			.STEP (i)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_valid  (chain_v[i]),
			.in_data   (chain_d[i]),
			.out_valid (chain_v[i+1]),
			.out_data  (chain_d[i+1])
		);
	end

	chp_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (chain_v[STEPS]),
		.in_data   (chain_d[STEPS]),
		.out_valid (fin_valid),
		.out_data  (fin_data)
	);

	// result beat
	assign result.valid         = fin_valid;
	assign result.scaled_x      = fin_data.scaled_x;
	assign result.scaled_y      = fin_data.scaled_y;
	assign result.scaled_z      = fin_data.scaled_z;
	assign result.heading_deg64 = fin_data.heading_deg64;
	assign result.status        = fin_data.status;

	// error beats carry nothing but the flag
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status |-> result.heading_deg64 == '0 &&
		result.scaled_x == '0 && result.scaled_y == '0 && result.scaled_z == '0)
		else $error("error beat carries nonzero fields");

	// heading stays within a full turn
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.heading_deg64 <= chp_pkg::HEADING_MAX)
		else $error("heading beyond 360 degrees");

	// a register write lands in the scale register
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr && (paddr[2] == chp_pkg::REG_SCALE) |=>
		scale_q == $past(pwdata[chp_pkg::SCALE_W-1:0]))
		else $error("scale register write lost");

	// a stalled result holds its place in the pipeline
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fin_valid && !result.ready |=> fin_valid && $stable(fin_data))
		else $error("stalled result changed");

endmodule

// ----- rtl/core/chp_front.sv -----
// front end: axis scaling, truncation toward zero and cordic vector setup
module chp_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_valid,
	input  logic signed [chp_pkg::AXIS_W-1:0] raw_x,
	input  logic signed [chp_pkg::AXIS_W-1:0] raw_y,
	input  logic signed [chp_pkg::AXIS_W-1:0] raw_z,
	input  logic                              read_error,
	input  logic [chp_pkg::SCALE_W-1:0]       scale,
	output logic                              out_valid,
	output chp_pkg::cordic_t                  out_data
);

	localparam int PW   = chp_pkg::PROD_W;
	localparam int AW   = chp_pkg::AXIS_W;
	localparam int VW   = chp_pkg::VEC_W;
	localparam int SH   = chp_pkg::VEC_SHIFT;
	localparam int FB   = chp_pkg::FRAC_BITS;
	localparam int EXTW = VW - AW - SH;

	logic                 valid_s1, valid_s2, valid_s3;
	logic                 err_s1, err_s2;
	logic signed [PW-1:0] px_s1, py_s1, pz_s1;
	logic signed [AW-1:0] sx_s2, sy_s2, sz_s2;
	logic signed [PW-1:0] scale_ext;
	chp_pkg::cordic_t     prep_s3;

	assign scale_ext = $signed({{(PW - chp_pkg::SCALE_W){1'b0}}, scale});

	// drop the fraction of a product, truncating toward zero
	function automatic logic signed [AW-1:0] trunc_q16(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] biased;
		biased = p + $signed({{(PW - FB){1'b0}}, {FB{p[PW-1]}}});
		return biased[FB +: AW];
	endfunction

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: multiply each axis by the sensitivity
	always_ff @(posedge clk) begin
		if (adv) begin
			err_s1 <= read_error;
			px_s1  <= PW'(raw_x) * scale_ext;
			py_s1  <= PW'(raw_y) * scale_ext;
			pz_s1  <= PW'(raw_z) * scale_ext;
		end
	end

	// stage 2: drop the fraction
	always_ff @(posedge clk) begin
		if (adv) begin
			err_s2 <= err_s1;
			sx_s2  <= trunc_q16(px_s1);
			sy_s2  <= trunc_q16(py_s1);
			sz_s2  <= trunc_q16(pz_s1);
		end
	end

	// stage 3: vector setup, scaled y is the x operand and scaled x the y operand
	logic signed [VW-1:0] vx, vy;
	logic                 ax_neg;
	chp_pkg::cordic_t     prep;

	assign vx     = $signed({{EXTW{sy_s2[AW-1]}}, sy_s2, {SH{1'b0}}});
	assign vy     = $signed({{EXTW{sx_s2[AW-1]}}, sx_s2, {SH{1'b0}}});
	assign ax_neg = sy_s2[AW-1];

	always_comb begin
		prep        = '0;
		prep.err    = err_s2;
		prep.y_zero = (sx_s2 == '0);
		prep.sx     = sx_s2;
		prep.sy     = sy_s2;
		prep.sz     = sz_s2;
		prep.z      = '0;
		if (ax_neg) begin
			// rotate into the right half plane
			prep.x    = -vx;
			prep.y    = -vy;
			prep.base = sx_s2[AW-1] ? chp_pkg::BASE_NEG : chp_pkg::BASE_POS;
		end else begin
			prep.x    = vx;
			prep.y    = vy;
			prep.base = chp_pkg::BASE_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prep_s3 <= prep;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = prep_s3;

endmodule

// ----- rtl/core/chp_cordic_stage.sv -----
// one vectoring rotation of the cordic pipeline
module chp_cordic_stage #(
	parameter int STEP = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_valid,
	input  chp_pkg::cordic_t in_data,
	output logic             out_valid,
	output chp_pkg::cordic_t out_data
);

	localparam logic signed [chp_pkg::ANG_W-1:0] ATAN = chp_pkg::atan_entry(STEP);

	logic signed [chp_pkg::VEC_W-1:0] x, y, xs, ys;
	logic                             valid_s1;
	chp_pkg::cordic_t                 nxt, data_s1;

	assign x  = in_data.x;
	assign y  = in_data.y;
	assign xs = x >>> STEP;
	assign ys = y >>> STEP;

	// rotate toward the x axis by the sign of y
	always_comb begin
		nxt = in_data;
		if (!y[chp_pkg::VEC_W-1]) begin
			nxt.x = x + ys;
			nxt.y = y - xs;
			nxt.z = in_data.z + ATAN;
		end else begin
			nxt.x = x - ys;
			nxt.y = y + xs;
			nxt.z = in_data.z - ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ----- rtl/core/chp_finish.sv -----
// back end: quadrant correction, rounding to 1/64 degree and clamping
module chp_finish (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_valid,
	input  chp_pkg::cordic_t in_data,
	output logic             out_valid,
	output chp_pkg::result_t out_data
);

	localparam int HW = chp_pkg::HSUM_W;
	localparam int FB = chp_pkg::FRAC_BITS;

	logic                  valid_s1, valid_s2;
	logic                  err_s1;
	logic signed [HW-1:0]  hsum_s1;
	logic signed [chp_pkg::AXIS_W-1:0] sx_s1, sy_s1, sz_s1;
	chp_pkg::result_t      res_s2;

	logic signed [HW-1:0]  z_eff, base_val, hsum;

	// angle from the rotations, zero when the y operand was zero
	assign z_eff = in_data.y_zero ? '0 : HW'(in_data.z);

	always_comb begin
		case (in_data.base)
			chp_pkg::BASE_POS: base_val = chp_pkg::DEG180;
			chp_pkg::BASE_NEG: base_val = -chp_pkg::DEG180;
			default:           base_val = '0;
		endcase
	end

	assign hsum = z_eff + base_val + chp_pkg::DEG180;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// stage 1: heading in fine units
	always_ff @(posedge clk) begin
		if (adv) begin
			err_s1  <= in_data.err;
			hsum_s1 <= hsum;
			sx_s1   <= in_data.sx;
			sy_s1   <= in_data.sy;
			sz_s1   <= in_data.sz;
		end
	end

	// stage 2: clamp below, round half up, clamp above
	logic [HW-1:0]      h_pos;
	logic [HW-1:0]      h_rnd;
	logic [HW-FB-1:0]   h_units;
	chp_pkg::result_t   res;

	assign h_pos   = hsum_s1[HW-1] ? '0 : hsum_s1;
	assign h_rnd   = h_pos + HW'(1 << (FB - 1));
	assign h_units = h_rnd[HW-1:FB];

	always_comb begin
		res = '0;
		if (err_s1) begin
			res.status = 1'b1;
		end else begin
			res.scaled_x = sx_s1;
			res.scaled_y = sy_s1;
			res.scaled_z = sz_s1;
			if (h_units > (HW - FB)'(chp_pkg::HEADING_MAX)) begin
				res.heading_deg64 = chp_pkg::HEADING_MAX;
			end else begin
				res.heading_deg64 = h_units[chp_pkg::HEAD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

endmodule

// ----- sim/compass_heading_from_magnetometer_core_tb.sv -----
// self-checking testbench of the compass heading core: directed and random samples, scale sweeps
`timescale 1ns / 1ps

module compass_heading_from_magnetometer_core_tb;

	localparam logic [chp_pkg::PADDR_W-1:0] ADDR_SCALE  = {chp_pkg::REG_SCALE, 2'b00};
	localparam logic [chp_pkg::PADDR_W-1:0] ADDR_UNUSED = 3'd4;
	localparam int PHASES     = 7;
	localparam int PHASE_LEN  = 250;
	localparam int DRAIN_WAIT = 50;

	// one magnetometer sample as offered on the sample channel
	typedef struct packed {
		logic signed [chp_pkg::AXIS_W-1:0] x;
		logic signed [chp_pkg::AXIS_W-1:0] y;
		logic signed [chp_pkg::AXIS_W-1:0] z;
		logic                              err;
	} sample_t;

	// heading predictor and queue of expected result beats
	class heading_scoreboard;
		longint scale;
		int unsigned errors;
		chp_pkg::result_t expected_q[$];
		longint atan_step[chp_pkg::STEPS];

		function new();
			scale = chp_pkg::SCALE_RESET;
			errors = 0;
			atan_step = '{188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
				3754631, 1877430, 938729, 469366, 234683, 117342, 58671, 29335,
				14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
		endfunction

		function void write_reg(int index, logic [31:0] value);
			if (index == chp_pkg::REG_SCALE)
				scale = value[chp_pkg::SCALE_W-1:0];
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void flag(string what, longint want, longint got);
			errors++;
			if (errors <= 10)
				$display("mismatch %s: expected %0d, got %0d", what, want, got);
		endfunction

		// vectoring cordic, angle of (ax, ay) in 1/(64*65536) degree
		function longint bearing_units(longint ay, longint ax);
			longint x, y, z, nx, base;
			if (ay == 0)
				return (ax < 0) ? 64'sd754974720 : 64'sd0;
			x = ax * 64'sd1073741824;
			y = ay * 64'sd1073741824;
			base = 0;
			// fold the left half plane onto the right one
			if (x < 0) begin
				base = (y >= 0) ? 64'sd754974720 : -64'sd754974720;
				x = -x;
				y = -y;
			end
			z = 0;
			for (int i = 0; i < chp_pkg::STEPS; i++) begin
				if (y >= 0) begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					z += atan_step[i];
				end else begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					z -= atan_step[i];
				end
				x = nx;
			end
			return base + z;
		endfunction

		function chp_pkg::result_t predict_heading(sample_t s);
			chp_pkg::result_t r;
			longint sx, sy, sz, h, hd;
			r = '0;
			if (s.err) begin
				r.status = 1'b1;
				return r;
			end
			// scaling truncates toward zero
			sx = (longint'(s.x) * scale) / 64'sd65536;
			sy = (longint'(s.y) * scale) / 64'sd65536;
			sz = (longint'(s.z) * scale) / 64'sd65536;
			h = bearing_units(sx, sy) + 64'sd754974720;
			if (h < 0)
				h = 0;
			hd = (h + 64'sd32768) >>> chp_pkg::FRAC_BITS;
			if (hd > longint'(chp_pkg::HEADING_MAX))
				hd = chp_pkg::HEADING_MAX;
			r.scaled_x = sx[chp_pkg::AXIS_W-1:0];
			r.scaled_y = sy[chp_pkg::AXIS_W-1:0];
			r.scaled_z = sz[chp_pkg::AXIS_W-1:0];
			r.heading_deg64 = hd[chp_pkg::HEAD_W-1:0];
			r.status = 1'b0;
			return r;
		endfunction

		function void note_sample(sample_t s);
			expected_q.push_back(predict_heading(s));
		endfunction

		function void check_result(chp_pkg::result_t got);
			chp_pkg::result_t want;
			if (expected_q.size() == 0) begin
				flag("result beat with nothing expected", 0, 1);
				return;
			end
			want = expected_q.pop_front();
			if (got.scaled_x !== want.scaled_x)
				flag("scaled_x", want.scaled_x, got.scaled_x);
			if (got.scaled_y !== want.scaled_y)
				flag("scaled_y", want.scaled_y, got.scaled_y);
			if (got.scaled_z !== want.scaled_z)
				flag("scaled_z", want.scaled_z, got.scaled_z);
			if (got.heading_deg64 !== want.heading_deg64)
				flag("heading_deg64", want.heading_deg64, got.heading_deg64);
			if (got.status !== want.status)
				flag("status", want.status, got.status);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [chp_pkg::PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	bit quiet;
	heading_scoreboard sb;

	chp_in_if  sample_ch ();
	chp_out_if result_ch ();

	compass_heading_from_magnetometer_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.sample  (sample_ch),
		.result  (result_ch)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// register write: setup phase, access phase, then the bus returns to idle
	task automatic apb_write(logic [chp_pkg::PADDR_W-1:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.write_reg(int'(addr >> 2), data);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// read the scale register back and compare with the model copy
	task automatic verify_scale();
		logic [31:0] rd;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_SCALE;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (rd[chp_pkg::SCALE_W-1:0] !== sb.scale[chp_pkg::SCALE_W-1:0])
			sb.flag("scale_q16 readback", sb.scale, rd[chp_pkg::SCALE_W-1:0]);
	endtask

	// offer one sample beat after a random gap and wait for it to be taken
	task automatic send_sample(sample_t s);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.raw_x <= s.x;
		sample_ch.raw_y <= s.y;
		sample_ch.raw_z <= s.z;
		sample_ch.read_error <= s.err;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		sb.note_sample(s);
	endtask

	// wait for every expected beat, then idle before the next phase
	task automatic drain();
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic sample_t mk(int x, int y, int z, bit e);
		sample_t s;
		s.x = x[chp_pkg::AXIS_W-1:0];
		s.y = y[chp_pkg::AXIS_W-1:0];
		s.z = z[chp_pkg::AXIS_W-1:0];
		s.err = e;
		return s;
	endfunction

	function automatic int edge_value();
		case ($urandom_range(0, 4))
			0:       return -32768;
			1:       return -1;
			2:       return 0;
			3:       return 1;
			default: return 32767;
		endcase
	endfunction

	// mostly full-range samples, with small, zero-axis, extreme and error ones mixed in
	function automatic sample_t draw_sample();
		int mode;
		sample_t s;
		mode = $urandom_range(0, 99);
		s = mk($urandom(), $urandom(), $urandom(), 1'b0);
		if (mode < 8) begin
			s.err = 1'b1;
		end else if (mode < 20) begin
			s.x = chp_pkg::AXIS_W'($urandom_range(0, 127) - 64);
			s.y = chp_pkg::AXIS_W'($urandom_range(0, 127) - 64);
		end else if (mode < 28) begin
			if ($urandom_range(0, 1))
				s.x = '0;
			else
				s.y = '0;
		end else if (mode < 34) begin
			s = mk(edge_value(), edge_value(), edge_value(), 1'b0);
		end
		return s;
	endfunction

	// result side: random stalls, checks every taken beat
	initial begin
		int gap;
		chp_pkg::result_t got;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			gap = quiet ? 0 : $urandom_range(0, 8);
			if (gap != 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid) @(posedge clk);
			got.scaled_x = result_ch.scaled_x;
			got.scaled_y = result_ch.scaled_y;
			got.scaled_z = result_ch.scaled_z;
			got.heading_deg64 = result_ch.heading_deg64;
			got.status = result_ch.status;
			sb.check_result(got);
		end
	end

	// main sequence
	initial begin
		sample_t directed[$];
		logic [31:0] wdata;
		logic [chp_pkg::SCALE_W-1:0] scale_val;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		sample_ch.valid <= 1'b0;
		sample_ch.raw_x <= '0;
		sample_ch.raw_y <= '0;
		sample_ch.raw_z <= '0;
		sample_ch.read_error <= 1'b0;
		arst_n <= 1'b0;
		quiet = 1'b0;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		verify_scale();

		// directed samples at the reset scale
		directed = '{
			mk(0, 0, 0, 0),              // both axes zero
			mk(0, -32768, 0, 0),         // x zero, y negative
			mk(0, 32767, 0, 0),          // x zero, y positive
			mk(32767, 32767, 32767, 0),
			mk(-32768, -32768, -32768, 0),
			mk(32767, -32768, 0, 0),
			mk(-32768, 32767, 0, 0),
			mk(7, -32768, 0, 0),         // heading just below 360
			mk(-7, -32768, 0, 0),        // heading just above 0
			mk(32767, 0, 0, 0),
			mk(-32768, 0, 0, 0),
			mk(1, 1, 1, 0),              // scales to zero
			mk(-1, -1, -1, 0),           // truncation toward zero
			mk(6, -6, 7, 0),
			mk(-7, 7, -6, 0),
			mk(100, 100, 100, 0),
			mk(-100, 100, 0, 0),
			mk(16'h5555, 16'haaaa, 16'h5555, 0),
			mk(16'haaaa, 16'h5555, 16'haaaa, 0),
			mk(32767, -32768, -1, 1),    // read error
			mk(0, 0, 0, 1),
			mk(-1, -1, -1, 1)
		};
		foreach (directed[i])
			send_sample(directed[i]);
		sample_ch.valid <= 1'b0;

		// random phases over a sweep of scales
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
				0:       scale_val = 16'd0;
				1:       scale_val = 16'hffff;
				2:       scale_val = 16'd1;
				3:       scale_val = 16'h8000;
				default: scale_val = chp_pkg::SCALE_W'($urandom());
			endcase
			wdata = $urandom();
			wdata[chp_pkg::SCALE_W-1:0] = scale_val;
			apb_write(ADDR_SCALE, wdata);
			// a write past the register list leaves the scale alone
			if (ph == 1)
				apb_write(ADDR_UNUSED, $urandom());
			verify_scale();
			quiet = (ph % 3 == 2);
			for (int n = 0; n < PHASE_LEN; n++) begin
				// hold the sender until the pipeline has emptied
				if (ph == 3 && n == PHASE_LEN / 2) begin
					sample_ch.valid <= 1'b0;
					while (sb.pending() != 0) @(posedge clk);
					@(posedge clk);
				end
				send_sample(draw_sample());
			end
			sample_ch.valid <= 1'b0;
		end

		drain();
		if (sb.errors == 0)
			$display("compass_heading_from_magnetometer_core_tb OK");
		else
			$display("compass_heading_from_magnetometer_core_tb NOT OK");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("compass_heading_from_magnetometer_core_tb NOT OK");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/chp_pkg.sv
rtl/core/chp_in_if.sv
rtl/core/chp_out_if.sv
rtl/core/chp_front.sv
rtl/core/chp_cordic_stage.sv
rtl/core/chp_finish.sv
rtl/core/compass_heading_from_magnetometer_core.sv
sim/compass_heading_from_magnetometer_core_tb.sv
